FILE: hw/rtl/rds_group_generator_core_macros.svh
// Assertion macros shared by the RDS group generator RTL.
`ifndef RDS_GROUP_GENERATOR_CORE_MACROS_SVH
`define RDS_GROUP_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define RDSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition that forces a consequence at the following clock edge.
`define RDSG_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define RDSG_ASSERT(lbl, prop, msg)
`define RDSG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hw/rtl/rdsg_pkg.sv
// Types, constants and checkword functions of the RDS group generator.
package rdsg_pkg;

	localparam int unsigned RT_WORDS_DEF = 16;

	localparam logic [9:0]  CRC_POLY     = 10'h1B9;
	localparam logic [3:0][9:0] OFFSET_WORD = {10'h1B4, 10'h168, 10'h198, 10'h0FC};

	localparam logic [15:0] GRP_1A_B     = 16'h1000;
	localparam logic [15:0] GRP_2A_B     = 16'h2000;
	localparam logic [3:0]  LIC_VARIANT  = 4'b0011;

	localparam logic [15:0] PI_RESET     = 16'h1234;
	localparam logic [6:0]  MODE_RESET   = 7'd4;

	localparam logic [2:0]  SLOT_1A      = 3'd3;
	localparam logic [2:0]  SLOT_RT      = 3'd4;

	localparam logic        FUNC_GROUP   = 1'b0;
	localparam logic        FUNC_RT_WR   = 1'b1;

	typedef enum logic [2:0] {
		REG_PI,
		REG_PTY,
		REG_MODE,
		REG_ENABLE,
		REG_ECC,
		REG_LIC,
		REG_PIN,
		REG_PS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_ECC,
		KIND_LIC,
		KIND_PIN
	} kind_1a_t;

	typedef struct packed {
		logic [15:0] pi;
		logic [4:0]  pty;
		logic [6:0]  mode;
		logic [2:0]  enable;
		logic [7:0]  ecc;
		logic [7:0]  lic;
		logic [15:0] pin;
		logic [63:0] ps;
	} cfg_t;

	// One group on its way to the serializer; the RadioText words of a 2A group
	// come from the text memory beside it.
	typedef struct packed {
		logic [15:0] blk_a;
		logic [15:0] blk_b;
		logic [15:0] blk_c;
		logic [15:0] blk_d;
		logic        is_rt;
		logic        rt_ok;
	} grp_t;

	function automatic logic [9:0] crc_serial(input logic [15:0] w);
		logic [9:0] r;
		logic       fb;
		r = '0;
		for (int k = 15; k >= 0; k--) begin
			fb = w[k] ^ r[9];
			r = {r[8:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic logic [15:0][9:0] crc_columns();
		logic [15:0][9:0] c;
		for (int i = 0; i < 16; i++) begin
			c[i] = crc_serial(16'(1) << i);
		end
		return c;
	endfunction

	// The checkword is linear in the data bits, so it is an XOR of columns.
	localparam logic [15:0][9:0] CRC_COL = crc_columns();

	function automatic logic [9:0] crc_par(input logic [15:0] w);
		logic [9:0] acc;
		acc = '0;
		for (int i = 0; i < 16; i++) begin
			if (w[i]) begin
				acc = acc ^ CRC_COL[i];
			end
		end
		return acc;
	endfunction

endpackage

FILE: hw/rtl/rdsg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module rdsg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/rdsg_build.sv
// Input side: text writes, slot and segment counters, group assembly stage.
`include "rds_group_generator_core_macros.svh"
module rdsg_build #(
	parameter int unsigned RT_WORDS = 16,
	localparam int unsigned AW = (RT_WORDS > 1) ? $clog2(RT_WORDS) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rdsg_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           func,
	input  logic [3:0]     rt_index,
	input  logic [31:0]    rt_chars,
	input  logic           ld_ready,
	output logic           grp_valid,
	output rdsg_pkg::grp_t grp,
	output logic           ram_we,
	output logic [AW-1:0]  ram_waddr,
	output logic [31:0]    ram_wdata,
	output logic           ram_re,
	output logic [AW-1:0]  ram_raddr
);
	import rdsg_pkg::*;

	logic [2:0]          slot_q;
	logic [1:0]          ps_seg_q;
	logic [3:0]          rt_seg_q;
	logic [1:0]          idx1a_q;
	logic [RT_WORDS-1:0] rt_ok_q;

	logic                vld_s1;
	grp_t                grp_s1;
	logic                rt_ok_s1;

	logic                acc;
	logic                acc_grp;
	logic                acc_wr;
	logic                send_1a;
	logic                send_rt;
	logic                both;
	logic                sel_hi;
	kind_1a_t            kind;
	logic [15:0]         common;
	logic                di;
	grp_t                grp_d;
	logic [4:0]          rt_seg_inc;

	assign in_ready = !vld_s1 || ld_ready;
	assign acc      = in_valid && in_ready;
	assign acc_grp  = acc && (func == FUNC_GROUP);
	assign acc_wr   = acc && (func == FUNC_RT_WR) && ({1'b0, rt_index} < 5'(RT_WORDS));

	assign ram_we    = acc_wr;
	assign ram_waddr = rt_index[AW-1:0];
	assign ram_wdata = rt_chars;
	assign send_1a   = (slot_q == SLOT_1A) && (cfg.enable != 3'd0);
	assign send_rt   = (slot_q == SLOT_RT);
	assign ram_re    = acc_grp && send_rt;
	assign ram_raddr = rt_seg_q[AW-1:0];

	assign rt_seg_inc = {1'b0, rt_seg_q} + 5'd1;

	always_comb begin
		both   = cfg.enable[0] && cfg.enable[1];
		sel_hi = both && idx1a_q[0];
		if (cfg.enable[0] && !sel_hi) begin
			kind = KIND_ECC;
		end else if (cfg.enable[1]) begin
			kind = KIND_LIC;
		end else begin
			kind = KIND_PIN;
		end

		common = (16'(cfg.mode[0]) << 10) | (16'(cfg.pty) << 5);

		case (ps_seg_q)
			2'd0:    di = cfg.mode[6];
			2'd1:    di = cfg.mode[5];
			2'd2:    di = cfg.mode[4];
			default: di = cfg.mode[3];
		endcase

		grp_d       = '0;
		grp_d.blk_a = cfg.pi;
		if (send_1a) begin
			grp_d.blk_b = GRP_1A_B | common;
			grp_d.blk_d = cfg.enable[2] ? cfg.pin : 16'h0000;
			unique case (kind)
				KIND_ECC: grp_d.blk_c = {8'h00, cfg.ecc};
				KIND_LIC: grp_d.blk_c = {LIC_VARIANT, 4'h0, cfg.lic};
				default:  grp_d.blk_c = cfg.pi;
			endcase
		end else if (send_rt) begin
			grp_d.blk_b = GRP_2A_B | common | (16'(cfg.mode[1]) << 4) | 16'(rt_seg_q);
			grp_d.is_rt = 1'b1;
		end else begin
			grp_d.blk_b = common | (16'(cfg.mode[1]) << 4) | (16'(cfg.mode[2]) << 3)
				| (16'(di) << 2) | 16'(ps_seg_q);
			case (ps_seg_q)
				2'd0:    grp_d.blk_d = cfg.ps[63:48];
				2'd1:    grp_d.blk_d = cfg.ps[47:32];
				2'd2:    grp_d.blk_d = cfg.ps[31:16];
				default: grp_d.blk_d = cfg.ps[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			ps_seg_q <= '0;
			rt_seg_q <= '0;
			idx1a_q  <= '0;
			rt_ok_q  <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (acc_wr) begin
				rt_ok_q[ram_waddr] <= 1'b1;
			end
			if (acc_grp) begin
				slot_q <= (slot_q >= SLOT_RT) ? 3'd0 : slot_q + 3'd1;
				if (send_1a) begin
					idx1a_q <= both ? {1'b0, idx1a_q[0]} + 2'd1 : 2'd1;
				end else if (send_rt) begin
					rt_seg_q <= (rt_seg_inc >= 5'(RT_WORDS)) ? 4'd0 : rt_seg_inc[3:0];
				end else begin
					ps_seg_q <= ps_seg_q + 2'd1;
				end
			end
			if (acc_grp) begin
				vld_s1 <= 1'b1;
			end else if (ld_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// The valid flag is sampled with the memory read so both hold while stalled.
	always_ff @(posedge clk) begin
		if (acc_grp) begin
			grp_s1 <= grp_d;
		end
		if (ram_re) begin
			rt_ok_s1 <= rt_ok_q[ram_raddr];
		end
	end

	always_comb begin
		grp       = grp_s1;
		grp.rt_ok = rt_ok_s1;
	end
	assign grp_valid = vld_s1;

	`RDSG_ASSERT(a_slot_range, slot_q <= SLOT_RT, "slot counter left its five-slot cycle")
	`RDSG_ASSERT(a_idx1a_range, idx1a_q != 2'd3, "1A index reached an unused value")
	`RDSG_ASSERT(a_stall_holds, !in_ready |-> vld_s1, "input stalled with an empty stage")
	`RDSG_ASSERT_NEXT(a_rt_read, ram_re, vld_s1 && grp_s1.is_rt,
		"text read issued without a 2A group in the stage")

endmodule

FILE: hw/rtl/rdsg_ser.sv
// Output side: holds one group and sends its four blocks with checkwords.
`include "rds_group_generator_core_macros.svh"
module rdsg_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld_valid,
	output logic           ld_ready,
	input  rdsg_pkg::grp_t grp,
	input  logic [31:0]    rt_word,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    info_word,
	output logic [9:0]     check_word,
	output logic [1:0]     block_number,
	output logic           last_block
);
	import rdsg_pkg::*;

	logic [3:0][15:0] blk_q;
	logic [1:0]       cnt_q;
	logic             vld_q;
	logic             take;
	logic             ld;
	logic [31:0]      rt_eff;

	assign take     = vld_q && out_ready;
	assign ld_ready = !vld_q || (take && (cnt_q == 2'd3));
	assign ld       = ld_valid && ld_ready;
	// Text words never written read as zero.
	assign rt_eff   = grp.rt_ok ? rt_word : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ld) begin
				vld_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (take) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			blk_q[0] <= grp.blk_a;
			blk_q[1] <= grp.blk_b;
			blk_q[2] <= grp.is_rt ? rt_eff[31:16] : grp.blk_c;
			blk_q[3] <= grp.is_rt ? rt_eff[15:0] : grp.blk_d;
		end
	end

	assign out_valid    = vld_q;
	assign info_word    = blk_q[cnt_q];
	assign check_word   = crc_par(blk_q[cnt_q]) ^ OFFSET_WORD[cnt_q];
	assign block_number = cnt_q;
	assign last_block   = (cnt_q == 2'd3);

	`RDSG_ASSERT(a_load_free, (ld && vld_q) |-> (out_ready && cnt_q == 2'd3),
		"group loaded over one still being sent")
	`RDSG_ASSERT_NEXT(a_drain, take && cnt_q == 2'd3 && !ld, !vld_q,
		"serializer busy after its last block with nothing loaded")

endmodule

FILE: hw/rtl/rds_group_generator_core.sv
// Top level of the RDS group generator: config registers, text memory, build and send.
// A group request is registered in the build stage and then in the serializer, which
// shows block A; blocks go out one a cycle while m_tready is high, and text writes one
// a cycle while s_tready is high; the next request is taken while blocks go out.
// Reset (arst_n, async, active low): counters clear, registers take their reset
// values and the text store reads as zeros through per-word valid flags; no clear pass.
module rds_group_generator_core #(
	parameter int unsigned RT_WORDS = rdsg_pkg::RT_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input word: tuser = func; tdata = rt_index[3:0], rt_chars[35:4], zero pad.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	// Output word: tdata = info_word[15:0], check_word[25:16], block_number[27:26],
	// zero pad; tlast = last_block.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	// Configuration write word: register index and data.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import rdsg_pkg::*;

	localparam int unsigned AW = (RT_WORDS > 1) ? $clog2(RT_WORDS) : 1;

	cfg_t          cfg_q;
	grp_t          grp;
	logic          grp_valid;
	logic          ld_ready;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [15:0]   info_word;
	logic [9:0]    check_word;
	logic [1:0]    block_number;

	// Configuration writes are always taken; software writes only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pi: PI_RESET, pty: 5'd0, mode: MODE_RESET, enable: 3'd0,
				ecc: 8'd0, lic: 8'd0, pin: 16'd0, ps: 64'd0};
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PI:     cfg_q.pi     <= cfg_data[15:0];
				REG_PTY:    cfg_q.pty    <= cfg_data[4:0];
				REG_MODE:   cfg_q.mode   <= cfg_data[6:0];
				REG_ENABLE: cfg_q.enable <= cfg_data[2:0];
				REG_ECC:    cfg_q.ecc    <= cfg_data[7:0];
				REG_LIC:    cfg_q.lic    <= cfg_data[7:0];
				REG_PIN:    cfg_q.pin    <= cfg_data[15:0];
				REG_PS:     cfg_q.ps     <= cfg_data;
				default:    cfg_q.ps     <= cfg_q.ps;
			endcase
		end
	end

	// Request decode, counters and the first pipeline stage; it also drives
	// the text memory, whose read lines up with that stage.
	rdsg_build #(
		.RT_WORDS (RT_WORDS)
	) u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.rt_index  (s_tdata[3:0]),
		.rt_chars  (s_tdata[35:4]),
		.ld_ready  (ld_ready),
		.grp_valid (grp_valid),
		.grp       (grp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// RadioText store, one 32-bit word per text segment.
	rdsg_ram #(
		.WIDTH (32),
		.DEPTH (RT_WORDS)
	) u_rt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Group buffer and block sequencer; the checkword is formed on the way out.
	rdsg_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld_valid     (grp_valid),
		.ld_ready     (ld_ready),
		.grp          (grp),
		.rt_word      (ram_rdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.info_word    (info_word),
		.check_word   (check_word),
		.block_number (block_number),
		.last_block   (m_tlast)
	);

	assign m_tdata = {4'h0, block_number, check_word, info_word};

endmodule
